// ----- design/spg_pkg.sv -----
// Shared types, constants and latency helpers for the sensor path geometry block.
package spg_pkg;

  localparam int unsigned LEN_MAX      = 2097151;
  localparam int unsigned UNIT_Q14     = 16384;
  localparam int          ANGLE_MAX    = 23040;
  localparam int          NORM_BITS    = 30;
  localparam int          CORDIC_STEPS = 20;
  localparam int          SQ_STEPS     = 22;
  localparam int          DIV_STEPS    = 15;

  localparam int unsigned ATAN_DEG16 [CORDIC_STEPS] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  typedef enum logic [2:0] {
    OUT_NORMAL     = 3'd0,
    OUT_COINCIDENT = 3'd1,
    OUT_OUTSIDE    = 3'd2,
    OUT_CLAMPED    = 3'd3,
    OUT_AXIS       = 3'd4
  } outcome_t;

  typedef struct packed {
    logic coin;
    logic outside;
    logic axis;
  } flags_t;

  function automatic int spg_norm_steps(input int w);
    int ak;
    ak = (2 * w + 1 > NORM_BITS) ? 2 * w + 1 - NORM_BITS : 0;
    return (ak > 0) ? $clog2(ak + 1) : 1;
  endfunction

  function automatic int spg_latency(input int w);
    return 59 + spg_norm_steps(w);
  endfunction

endpackage

// ----- design/spg_isqrt.sv -----
// Pipelined floor square root with remainder, one result bit per stage.
module spg_isqrt import spg_pkg::*; #(
  parameter int IN_W = 62
) (
  input  logic                     clk,
  input  logic [IN_W-1:0]          value,
  output logic [(IN_W+1)/2-1:0]    root,
  output logic [(IN_W+1)/2:0]      rem
);

  localparam int RW = (IN_W + 1) / 2;
  localparam int PW = 2 * RW;

  logic [RW+1:0] st_rem  [RW];
  logic [RW-1:0] st_root [RW];
  logic [PW-1:0] st_src  [RW];

  for (genvar g = 0; g < RW; g++) begin : g_stage
    logic [RW+1:0] pr_rem;
    logic [RW-1:0] pr_root;
    logic [PW-1:0] pr_src;
    logic [RW+3:0] cand;
    logic [RW+3:0] trial;
    logic [RW+1:0] nrem;
    logic [RW-1:0] nroot;

    if (g == 0) begin : g_first
      assign pr_rem  = '0;
      assign pr_root = '0;
      assign pr_src  = PW'(value);
    end else begin : g_next
      assign pr_rem  = st_rem[g-1];
      assign pr_root = st_root[g-1];
      assign pr_src  = st_src[g-1];
    end

    always_comb begin
      cand  = {pr_rem, pr_src[PW-1:PW-2]};
      trial = {2'b00, pr_root, 2'b01};
      if (cand >= trial) begin
        nrem  = (RW+2)'(cand - trial);
        nroot = RW'({pr_root, 1'b1});
      end else begin
        nrem  = (RW+2)'(cand);
        nroot = RW'({pr_root, 1'b0});
      end
    end

    always_ff @(posedge clk) begin
      st_rem[g]  <= nrem;
      st_root[g] <= nroot;
      st_src[g]  <= pr_src << 2;
    end
  end

  assign root = st_root[RW-1];
  assign rem  = st_rem[RW-1][RW:0];

endmodule

// ----- design/sensor_path_geometry.sv -----
// Top level: pipelined distance, direction and incidence angle of a sensor hit.
//
//  channel  | handshake    | beat
//  ---------+--------------+-------------------------------------------------
//  command  | start / busy | point_x..z, sensor_x..z (COORD_WIDTH, signed)
//  result   | done         | path_length, incidence_angle, dir_x..z, outcome
//
//  One beat enters per cycle; busy stays low.
//  The angle path sets the latency: its normalising steps (4 at the default
//  width), the angle root (31 stages) and the 20-step CORDIC.
//  Synchronous reset clears the valid chain only; no results appear after it.
//  The receiver cannot stall: each result shows on done for one cycle.
module sensor_path_geometry import spg_pkg::*; #(
  parameter int COORD_WIDTH = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] point_z,
  input  logic signed [COORD_WIDTH-1:0] sensor_x,
  input  logic signed [COORD_WIDTH-1:0] sensor_y,
  input  logic signed [COORD_WIDTH-1:0] sensor_z,
  output logic                          done,
  output logic [20:0]                   path_length,
  output logic signed [15:0]            incidence_angle,
  output logic signed [15:0]            dir_x,
  output logic signed [15:0]            dir_y,
  output logic signed [15:0]            dir_z,
  output logic [2:0]                    outcome
);

  localparam int W   = COORD_WIDTH;
  localparam int AW  = 2 * W + 1;
  localparam int GW  = (AW > NORM_BITS) ? AW : NORM_BITS;
  localparam int ANS = spg_norm_steps(W);
  localparam int EF  = spg_latency(W);
  localparam int AXW = (W + 1 > 21) ? W + 1 : 21;

  localparam int D_XN   = 33;
  localparam int D_N    = 33;
  localparam int D_NEG  = 49;
  localparam int D_LSAT = 22;
  localparam int D_LEN  = 31 + ANS;
  localparam int D_DIR  = 5 + ANS;
  localparam int D_FLG  = 53 + ANS;

  logic [EF:1] vld;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[EF-1:1], start & ~busy};
    end
  end

  // stage 1: capture
  logic signed [W-1:0] s1_v [3];
  logic signed [W-1:0] s1_p [3];

  always_ff @(posedge clk) begin
    s1_v[0] <= point_x;
    s1_v[1] <= point_y;
    s1_v[2] <= point_z;
    s1_p[0] <= sensor_x;
    s1_p[1] <= sensor_y;
    s1_p[2] <= sensor_z;
  end

  // stage 2: differences
  logic signed [W-1:0] s2_v [3];
  logic signed [W-1:0] s2_p [3];
  logic signed [W:0]   s2_q [3];
  logic [W:0]          s2_a [3];
  logic                s2_neg [3];
  logic signed [W:0]   c2_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c2_d[i] = (W+1)'(s1_v[i]) - (W+1)'(s1_p[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_v[i]   <= s1_v[i];
      s2_p[i]   <= s1_p[i];
      s2_q[i]   <= -c2_d[i];
      s2_a[i]   <= c2_d[i][W] ? (W+1)'(-c2_d[i]) : (W+1)'(c2_d[i]);
      s2_neg[i] <= c2_d[i][W];
    end
  end

  // stage 3: products and direction normalising
  logic [W:0]           c3_or;
  logic [W:0]           c3_nt [3];
  logic [AXW-1:0]       c3_ax [3];
  logic [W-1:0]         c3_mv [3];
  logic [W-1:0]         c3_mp [3];

  logic [41:0]          s3_lsq [3];
  logic                 s3_lsat;
  logic [29:0]          s3_n [3];
  logic [2:0]           s3_neg;
  logic                 s3_coin;
  logic [2*W-1:0]       s3_mv2 [3];
  logic [2*W-1:0]       s3_mp2 [3];
  logic signed [2*W-1:0] s3_xa [3];
  logic signed [2*W-1:0] s3_xb [3];
  logic signed [2*W:0]  s3_t [3];

  always_comb begin
    c3_or = s2_a[0] | s2_a[1] | s2_a[2];
    for (int i = 0; i < 3; i++) begin
      c3_nt[i] = s2_a[i];
      for (int b = NORM_BITS; b <= W; b++) begin
        if (c3_or[b]) begin
          c3_nt[i] = s2_a[i] >> (b - NORM_BITS + 1);
        end
      end
      c3_ax[i] = AXW'(s2_a[i]);
      c3_mv[i] = s2_v[i][W-1] ? W'(-s2_v[i]) : W'(s2_v[i]);
      c3_mp[i] = s2_p[i][W-1] ? W'(-s2_p[i]) : W'(s2_p[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_lsq[i] <= 42'(c3_ax[i][20:0]) * 42'(c3_ax[i][20:0]);
      s3_n[i]   <= 30'(c3_nt[i]);
      s3_neg[i] <= s2_neg[i];
      s3_mv2[i] <= (2*W)'(c3_mv[i]) * (2*W)'(c3_mv[i]);
      s3_mp2[i] <= (2*W)'(c3_mp[i]) * (2*W)'(c3_mp[i]);
      s3_xa[i]  <= s2_v[(i+1)%3] * s2_p[(i+2)%3];
      s3_xb[i]  <= s2_v[(i+2)%3] * s2_p[(i+1)%3];
      s3_t[i]   <= s2_p[i] * s2_q[i];
    end
    s3_lsat <= (c3_ax[0] > AXW'(LEN_MAX)) || (c3_ax[1] > AXW'(LEN_MAX)) ||
               (c3_ax[2] > AXW'(LEN_MAX));
    s3_coin <= (c3_or == '0);
  end

  // stage 4: sums and cross magnitudes
  logic signed [2*W:0]   c4_df [3];
  logic signed [2*W+2:0] c4_x;

  logic [43:0]           s4_lsum;
  logic                  s4_lsat;
  logic [59:0]           s4_nsq [3];
  logic [2*W+1:0]        s4_rv2;
  logic [2*W+1:0]        s4_rp2;
  logic [2*W-1:0]        s4_cm [3];
  logic [AW-1:0]         s4_x;
  logic                  s4_coin;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c4_df[i] = (2*W+1)'(s3_xa[i]) - (2*W+1)'(s3_xb[i]);
    end
    c4_x = (2*W+3)'(s3_t[0]) + (2*W+3)'(s3_t[1]) + (2*W+3)'(s3_t[2]);
  end

  always_ff @(posedge clk) begin
    s4_lsum <= 44'(s3_lsq[0]) + 44'(s3_lsq[1]) + 44'(s3_lsq[2]);
    s4_lsat <= s3_lsat;
    for (int i = 0; i < 3; i++) begin
      s4_nsq[i] <= 60'(s3_n[i]) * 60'(s3_n[i]);
      s4_cm[i]  <= c4_df[i][2*W] ? (2*W)'(-c4_df[i]) : (2*W)'(c4_df[i]);
    end
    s4_rv2  <= (2*W+2)'(s3_mv2[0]) + (2*W+2)'(s3_mv2[1]) + (2*W+2)'(s3_mv2[2]);
    s4_rp2  <= (2*W+2)'(s3_mp2[0]) + (2*W+2)'(s3_mp2[1]) + (2*W+2)'(s3_mp2[2]);
    s4_x    <= AW'(c4_x);
    s4_coin <= s3_coin;
  end

  // stage 5: flags and direction sum
  logic [61:0] s5_nsum;
  flags_t      s5_flg;

  always_ff @(posedge clk) begin
    s5_nsum        <= 62'(s4_nsq[0]) + 62'(s4_nsq[1]) + 62'(s4_nsq[2]);
    s5_flg.coin    <= s4_coin;
    s5_flg.outside <= (s4_rv2 >= s4_rp2);
    s5_flg.axis    <= (s4_cm[0] == '0) && (s4_cm[1] == '0) && (s4_cm[2] == '0);
  end

  // angle normalising: binary search on the common shift
  logic [GW-1:0] an_x [ANS];
  logic [GW-1:0] an_c [ANS][3];
  logic [GW-1:0] an_o [ANS];

  for (genvar j = 0; j < ANS; j++) begin : g_norm
    localparam int SH = 1 << (ANS - 1 - j);
    logic [GW-1:0] pr_x;
    logic [GW-1:0] pr_c [3];
    logic [GW-1:0] pr_o;
    logic          take;

    if (j == 0) begin : g_first
      assign pr_x    = GW'(s4_x);
      assign pr_c[0] = GW'(s4_cm[0]);
      assign pr_c[1] = GW'(s4_cm[1]);
      assign pr_c[2] = GW'(s4_cm[2]);
      assign pr_o    = GW'(s4_x) | GW'(s4_cm[0]) | GW'(s4_cm[1]) | GW'(s4_cm[2]);
    end else begin : g_next
      assign pr_x    = an_x[j-1];
      assign pr_c[0] = an_c[j-1][0];
      assign pr_c[1] = an_c[j-1][1];
      assign pr_c[2] = an_c[j-1][2];
      assign pr_o    = an_o[j-1];
    end

    assign take = (pr_o >> (NORM_BITS - 1 + SH)) != '0;

    always_ff @(posedge clk) begin
      an_x[j] <= take ? pr_x >> SH : pr_x;
      an_o[j] <= take ? pr_o >> SH : pr_o;
      for (int i = 0; i < 3; i++) begin
        an_c[j][i] <= take ? pr_c[i] >> SH : pr_c[i];
      end
    end
  end

  logic [59:0] ag_sq [3];
  logic [61:0] ag_sum;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ag_sq[i] <= 60'(an_c[ANS-1][i][29:0]) * 60'(an_c[ANS-1][i][29:0]);
    end
    ag_sum <= 62'(ag_sq[0]) + 62'(ag_sq[1]) + 62'(ag_sq[2]);
  end

  // square roots
  logic [21:0] len_root;
  logic [22:0] len_rem;
  logic [30:0] dir_root;
  logic [31:0] dir_rem;
  logic [30:0] ang_root;
  logic [31:0] ang_rem;

  spg_isqrt #(.IN_W(44)) u_len_sqrt (
    .clk   (clk),
    .value (s4_lsum),
    .root  (len_root),
    .rem   (len_rem)
  );

  spg_isqrt #(.IN_W(62)) u_dir_sqrt (
    .clk   (clk),
    .value (s5_nsum),
    .root  (dir_root),
    .rem   (dir_rem)
  );

  spg_isqrt #(.IN_W(62)) u_ang_sqrt (
    .clk   (clk),
    .value (ag_sum),
    .root  (ang_root),
    .rem   (ang_rem)
  );

  // delay lines
  logic [29:0]       dl_xn   [D_XN];
  logic [2:0][29:0]  dl_n    [D_N];
  logic [2:0]        dl_neg  [D_NEG];
  logic              dl_lsat [D_LSAT];
  logic [20:0]       dl_len  [D_LEN];
  logic [2:0][15:0]  dl_dir  [D_DIR];
  flags_t            dl_flg  [D_FLG];

  logic [20:0]       len_res;
  logic [2:0][15:0]  dir_res;

  always_ff @(posedge clk) begin
    dl_xn[0]   <= an_x[ANS-1][29:0];
    dl_n[0]    <= {s3_n[2], s3_n[1], s3_n[0]};
    dl_neg[0]  <= s3_neg;
    dl_lsat[0] <= s4_lsat;
    dl_len[0]  <= len_res;
    dl_dir[0]  <= dir_res;
    dl_flg[0]  <= s5_flg;
    for (int i = 1; i < D_XN; i++)   dl_xn[i]   <= dl_xn[i-1];
    for (int i = 1; i < D_N; i++)    dl_n[i]    <= dl_n[i-1];
    for (int i = 1; i < D_NEG; i++)  dl_neg[i]  <= dl_neg[i-1];
    for (int i = 1; i < D_LSAT; i++) dl_lsat[i] <= dl_lsat[i-1];
    for (int i = 1; i < D_LEN; i++)  dl_len[i]  <= dl_len[i-1];
    for (int i = 1; i < D_DIR; i++)  dl_dir[i]  <= dl_dir[i-1];
    for (int i = 1; i < D_FLG; i++)  dl_flg[i]  <= dl_flg[i-1];
  end

  // length rounding
  logic [22:0] c_len;

  always_comb begin
    c_len = 23'(len_root) + 23'(len_rem > 23'(len_root));
  end

  always_ff @(posedge clk) begin
    if (dl_lsat[D_LSAT-1] || (c_len > 23'(LEN_MAX))) begin
      len_res <= 21'(LEN_MAX);
    end else begin
      len_res <= c_len[20:0];
    end
  end

  // direction division
  logic [45:0] dv_n0 [3];
  logic [31:0] dv_d0;
  logic [45:0] dv_r [DIV_STEPS][3];
  logic [14:0] dv_q [DIV_STEPS][3];
  logic [31:0] dv_d [DIV_STEPS];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_n0[i] <= {1'b0, dl_n[D_N-1][i], 15'd0} + 46'(dir_root);
    end
    dv_d0 <= {dir_root, 1'b0};
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int B = DIV_STEPS - 1 - j;
    logic [45:0] pr_r [3];
    logic [14:0] pr_q [3];
    logic [31:0] pr_d;
    logic [46:0] dsh;

    if (j == 0) begin : g_first
      assign pr_r[0] = dv_n0[0];
      assign pr_r[1] = dv_n0[1];
      assign pr_r[2] = dv_n0[2];
      assign pr_q[0] = '0;
      assign pr_q[1] = '0;
      assign pr_q[2] = '0;
      assign pr_d    = dv_d0;
    end else begin : g_next
      assign pr_r[0] = dv_r[j-1][0];
      assign pr_r[1] = dv_r[j-1][1];
      assign pr_r[2] = dv_r[j-1][2];
      assign pr_q[0] = dv_q[j-1][0];
      assign pr_q[1] = dv_q[j-1][1];
      assign pr_q[2] = dv_q[j-1][2];
      assign pr_d    = dv_d[j-1];
    end

    assign dsh = 47'(pr_d) << B;

    always_ff @(posedge clk) begin
      dv_d[j] <= pr_d;
      for (int i = 0; i < 3; i++) begin
        if (47'(pr_r[i]) >= dsh) begin
          dv_r[j][i] <= 46'(47'(pr_r[i]) - dsh);
          dv_q[j][i] <= pr_q[i] | (15'd1 << B);
        end else begin
          dv_r[j][i] <= pr_r[i];
          dv_q[j][i] <= pr_q[i];
        end
      end
    end
  end

  logic [15:0] c_dq [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_dq[i] = (dv_q[DIV_STEPS-1][i] > 15'(UNIT_Q14)) ? 16'(UNIT_Q14)
                                                        : 16'(dv_q[DIV_STEPS-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dir_res[i] <= dl_neg[D_NEG-1][i] ? 16'(-c_dq[i]) : c_dq[i];
    end
  end

  // CORDIC vectoring
  logic signed [33:0] cx [CORDIC_STEPS];
  logic signed [33:0] cy [CORDIC_STEPS];
  logic signed [24:0] cz [CORDIC_STEPS];

  for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
    logic signed [33:0] pr_x;
    logic signed [33:0] pr_y;
    logic signed [24:0] pr_z;
    logic signed [33:0] sx;
    logic signed [33:0] sy;

    if (j == 0) begin : g_first
      assign pr_x = 34'(dl_xn[D_XN-1]);
      assign pr_y = 34'(ang_root);
      assign pr_z = '0;
    end else begin : g_next
      assign pr_x = cx[j-1];
      assign pr_y = cy[j-1];
      assign pr_z = cz[j-1];
    end

    assign sx = pr_x >>> j;
    assign sy = pr_y >>> j;

    always_ff @(posedge clk) begin
      if (pr_y > 0) begin
        cx[j] <= pr_x + sy;
        cy[j] <= pr_y - sx;
        cz[j] <= pr_z + 25'(ATAN_DEG16[j]);
      end else begin
        cx[j] <= pr_x - sy;
        cy[j] <= pr_y + sx;
        cz[j] <= pr_z - 25'(ATAN_DEG16[j]);
      end
    end
  end

  logic signed [24:0] c_zr;
  logic signed [16:0] c_rr;
  logic [15:0]        ang_res;

  always_comb begin
    c_zr = cz[CORDIC_STEPS-1] + 25'sd128;
    c_rr = 17'(c_zr >>> 8);
  end

  always_ff @(posedge clk) begin
    if (c_rr < 0) begin
      ang_res <= '0;
    end else if (c_rr > 17'(ANGLE_MAX)) begin
      ang_res <= 16'(ANGLE_MAX);
    end else begin
      ang_res <= 16'(c_rr);
    end
  end

  // result
  flags_t   fl;
  outcome_t oc;

  assign fl = dl_flg[D_FLG-1];

  always_ff @(posedge clk) begin
    if (fl.coin) begin
      path_length     <= '0;
      incidence_angle <= '0;
      dir_x           <= '0;
      dir_y           <= '0;
      dir_z           <= '0;
      oc              <= OUT_COINCIDENT;
    end else begin
      path_length <= dl_len[D_LEN-1];
      dir_x       <= dl_dir[D_DIR-1][0];
      dir_y       <= dl_dir[D_DIR-1][1];
      dir_z       <= dl_dir[D_DIR-1][2];
      priority if (fl.outside) begin
        incidence_angle <= 16'(-ANGLE_MAX);
        oc              <= OUT_OUTSIDE;
      end else if (fl.axis) begin
        incidence_angle <= '0;
        oc              <= OUT_AXIS;
      end else begin
        incidence_angle <= ang_res;
        oc              <= OUT_NORMAL;
      end
    end
  end

  assign outcome = oc;
  assign done    = vld[EF];

endmodule

// ----- design/spg_check.sv -----
// Port-level checks of the sensor path geometry block and their binding.
module spg_check import spg_pkg::*; #(
  parameter int COORD_WIDTH = 20
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [20:0]                   path_length,
  input logic signed [15:0]            incidence_angle,
  input logic signed [15:0]            dir_x,
  input logic signed [15:0]            dir_y,
  input logic signed [15:0]            dir_z,
  input logic [2:0]                    outcome
);

  localparam int LAT = spg_latency(COORD_WIDTH);

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result beat without matching command");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (outcome == OUT_NORMAL || outcome == OUT_COINCIDENT ||
              outcome == OUT_OUTSIDE || outcome == OUT_AXIS))
    else $error("unexpected outcome code");

  a_coincident_zero: assert property (@(posedge clk) disable iff (rst)
    done && outcome == OUT_COINCIDENT |->
      path_length == '0 && incidence_angle == '0 &&
      dir_x == '0 && dir_y == '0 && dir_z == '0)
    else $error("coincident result not cleared");

  a_outside_angle: assert property (@(posedge clk) disable iff (rst)
    done && outcome == OUT_OUTSIDE |-> incidence_angle == 16'(-ANGLE_MAX))
    else $error("outside result angle wrong");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    done && (outcome == OUT_NORMAL || outcome == OUT_AXIS) |->
      incidence_angle >= 0 && incidence_angle <= 16'(ANGLE_MAX))
    else $error("angle out of range");

endmodule

bind sensor_path_geometry spg_check #(.COORD_WIDTH(COORD_WIDTH)) u_spg_check (.*);
